// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, disabled in reset.
`define AM_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check: when the trigger holds, the consequence holds in the next cycle.
`define AM_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: design/rgbcs_pkg.sv
// Shared constants for the RGB 2x2 chroma subsampler.
// No dependencies; used by the interfaces, the top level and the checker.
package rgbcs_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int PAIR_W      = SAMPLE_W + 1;
  localparam int COORD_W     = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

endpackage

// File: design/rgbcs_pixel_if.sv
// Valid/ready channel carrying one RGB input pixel per beat.
// Depends on rgbcs_pkg for the sample width.
interface rgbcs_pixel_if
  import rgbcs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red_in;
  logic [SAMPLE_W-1:0] green_in;
  logic [SAMPLE_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// File: design/rgbcs_result_if.sv
// Valid/ready channel carrying one subsampler result per beat.
// Depends on rgbcs_pkg for the sample and coordinate widths.
interface rgbcs_result_if
  import rgbcs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] green_out;
  logic                chroma_valid;
  logic [SAMPLE_W-1:0] red_average;
  logic [SAMPLE_W-1:0] blue_average;
  logic [COORD_W-1:0]  block_column;
  logic [COORD_W-1:0]  block_row;
  logic                frame_end;

  modport source (
    output valid, output green_out, output chroma_valid, output red_average,
    output blue_average, output block_column, output block_row, output frame_end,
    input ready
  );
  modport sink (
    input valid, input green_out, input chroma_valid, input red_average,
    input blue_average, input block_column, input block_row, input frame_end,
    output ready
  );
endinterface

// File: design/rgbcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rgbcs_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2048
) (
  input  logic                                        clk,
  input  logic                                        write_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
  input  logic [WIDTH-1:0]                            write_data,
  input  logic                                        read_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
  output logic [WIDTH-1:0]                            read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
    if (read_en) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

// File: design/rgb_chroma_2x2_subsampler.sv
// Top level of the RGB 2x2 chroma subsampler.
// Depends on rgbcs_pkg, rgbcs_pixel_if, rgbcs_result_if and rgbcs_ram.
//
// Usage: pixels arrive in raster order on the pixels channel, one per beat.
// Every pixel yields exactly one beat on the results channel: green passes
// through, and on the bottom-right pixel of each 2x2 block chroma_valid is
// set with the truncated means of the block's red and blue samples and the
// block coordinates. An odd last column or row forms no block. frame_end
// marks the last pixel of a frame. Image width and height are written on
// the register port while the block is idle; zero acts as one and values
// above the maximum act as the maximum.
// Pipeline: an accepted pixel is registered in the input stage and then in
// the result register, from which its result beat is taken. One pixel is
// taken every cycle while the receiver does not stall; the line store read is
// issued at acceptance and combined in the second stage.
// Reset returns the position to the frame start and the sizes to 640x480.
// The line store is not cleared, since each block's top row is written
// before its bottom row reads it.
// When the receiver stalls, the result holds; the input stage keeps taking
// pixels until both stages are full and then drops ready.
module rgb_chroma_2x2_subsampler
  import rgbcs_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] register_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  rgbcs_pixel_if.sink            pixels,
  rgbcs_result_if.source         results
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int BIG_W  = (WID_W > HGT_W) ? WID_W : HGT_W;
  localparam int CMP_W  = ((BIG_W > CFG_DATA_W) ? BIG_W : CFG_DATA_W) + 1;
  localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = PAIR_W + 1;

  typedef struct packed {
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] red;
  } pair_sums_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] green;
    pair_sums_t          pair;
    logic                is_block;
    logic [COORD_W-1:0]  block_column;
    logic [COORD_W-1:0]  block_row;
    logic                frame_end;
  } stage_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] green_out;
    logic                chroma_valid;
    logic [SAMPLE_W-1:0] red_average;
    logic [SAMPLE_W-1:0] blue_average;
    logic [COORD_W-1:0]  block_column;
    logic [COORD_W-1:0]  block_row;
    logic                frame_end;
  } result_t;

  function automatic logic [CMP_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                                 input logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] x;
    x = CMP_W'(v);
    if (x == '0) begin
      return CMP_W'(1);
    end else if (x > lim) begin
      return lim;
    end
    return x;
  endfunction

  logic [WID_W-1:0]    width_lim;
  logic [HGT_W-1:0]    height_lim;
  logic [COL_W-1:0]    column;
  logic [ROW_W-1:0]    row;
  logic [SAMPLE_W-1:0] hold_red;
  logic [SAMPLE_W-1:0] hold_blue;
  logic                stage_valid;
  stage_t              stage;
  logic                result_valid;
  result_t             result;

  logic                out_free;
  logic                stage_move;
  logic                accept;
  logic                col_wrap;
  logic                row_wrap;
  pair_sums_t          pair_now;
  pair_sums_t          top_pair;
  logic                store_write;
  logic                store_read;
  logic [ADDR_W-1:0]   store_addr;
  stage_t              stage_next;
  result_t             result_next;
  logic [SUM_W-1:0]    red_sum;
  logic [SUM_W-1:0]    blue_sum;

  assign out_free   = !result_valid || results.ready;
  assign stage_move = stage_valid && out_free;
  assign pixels.ready = !stage_valid || out_free;
  assign accept     = pixels.valid && pixels.ready;

  assign col_wrap = (CMP_W'(column) + CMP_W'(1)) >= CMP_W'(width_lim);
  assign row_wrap = (CMP_W'(row) + CMP_W'(1)) >= CMP_W'(height_lim);

  assign pair_now.red  = PAIR_W'(hold_red) + PAIR_W'(pixels.red_in);
  assign pair_now.blue = PAIR_W'(hold_blue) + PAIR_W'(pixels.blue_in);

  assign store_addr  = ADDR_W'(column >> 1);
  assign store_write = accept && column[0] && !row[0];
  assign store_read  = accept;

  rgbcs_ram #(
    .WIDTH ($bits(pair_sums_t)),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk        (clk),
    .write_en   (store_write),
    .write_addr (store_addr),
    .write_data (pair_now),
    .read_en    (store_read),
    .read_addr  (store_addr),
    .read_data  (top_pair)
  );

  always_comb begin
    stage_next.green        = pixels.green_in;
    stage_next.pair         = pair_now;
    stage_next.is_block     = column[0] && row[0];
    stage_next.block_column = stage_next.is_block ? COORD_W'(column >> 1) : '0;
    stage_next.block_row    = stage_next.is_block ? COORD_W'(row >> 1) : '0;
    stage_next.frame_end    = col_wrap && row_wrap;
  end

  always_comb begin
    red_sum  = SUM_W'(top_pair.red) + SUM_W'(stage.pair.red);
    blue_sum = SUM_W'(top_pair.blue) + SUM_W'(stage.pair.blue);
    result_next.green_out    = stage.green;
    result_next.chroma_valid = stage.is_block;
    result_next.red_average  = stage.is_block ? red_sum[SUM_W-1:2] : '0;
    result_next.blue_average = stage.is_block ? blue_sum[SUM_W-1:2] : '0;
    result_next.block_column = stage.block_column;
    result_next.block_row    = stage.block_row;
    result_next.frame_end    = stage.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= WID_W'(clamp_size(CFG_DATA_W'(RESET_WIDTH), CMP_W'(MAX_WIDTH)));
      height_lim <= HGT_W'(clamp_size(CFG_DATA_W'(RESET_HEIGHT), CMP_W'(MAX_HEIGHT)));
    end else if (write_enable) begin
      unique case (register_index)
        REG_IMAGE_WIDTH: begin
          width_lim <= WID_W'(clamp_size(write_data, CMP_W'(MAX_WIDTH)));
        end
        REG_IMAGE_HEIGHT: begin
          height_lim <= HGT_W'(clamp_size(write_data, CMP_W'(MAX_HEIGHT)));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row       <= '0;
      hold_red  <= '0;
      hold_blue <= '0;
    end else if (accept) begin
      if (!column[0]) begin
        hold_red  <= pixels.red_in;
        hold_blue <= pixels.blue_in;
      end
      if (col_wrap) begin
        column <= '0;
        row    <= row_wrap ? '0 : ROW_W'(row + 1'b1);
      end else begin
        column <= COL_W'(column + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_move) begin
        stage_valid <= 1'b0;
      end
      if (stage_move) begin
        result_valid <= 1'b1;
      end else if (results.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
    if (stage_move) begin
      result <= result_next;
    end
  end

  assign results.valid        = result_valid;
  assign results.green_out    = result.green_out;
  assign results.chroma_valid = result.chroma_valid;
  assign results.red_average  = result.red_average;
  assign results.blue_average = result.blue_average;
  assign results.block_column = result.block_column;
  assign results.block_row    = result.block_row;
  assign results.frame_end    = result.frame_end;

endmodule

// File: design/rgbcs_checker.sv
// Port-level checks for the RGB 2x2 chroma subsampler, bound to the top level.
// Depends on rgbcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rgbcs_checker
  import rgbcs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] green_out,
  input logic                chroma_valid,
  input logic [SAMPLE_W-1:0] red_average,
  input logic [SAMPLE_W-1:0] blue_average,
  input logic [COORD_W-1:0]  block_column,
  input logic [COORD_W-1:0]  block_row,
  input logic                frame_end
);

  // A beat that completes no block carries zero chroma fields.
  `AM_CHECK(a_no_block_zero, clk, rst, (out_valid && !chroma_valid) |-> (red_average == '0 && blue_average == '0 && block_column == '0 && block_row == '0), "chroma fields not zero without a completed block")

  // With no result waiting, the pipeline always has room for a pixel.
  `AM_CHECK(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "input stalled while the output is empty")

  // A pixel taken is registered in the input stage and reaches the output once out_ready is then high.
  `AM_CHECK(a_latency, clk, rst, (in_valid && in_ready) ##1 out_ready |=> out_valid, "accepted pixel did not reach the output in two cycles")

  // A stalled result beat holds its payload.
  `AM_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(green_out) && $stable(chroma_valid) && $stable(red_average) && $stable(blue_average) && $stable(block_column) && $stable(block_row) && $stable(frame_end), "stalled result beat changed")

endmodule

bind rgb_chroma_2x2_subsampler rgbcs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (pixels.valid),
  .in_ready     (pixels.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .green_out    (results.green_out),
  .chroma_valid (results.chroma_valid),
  .red_average  (results.red_average),
  .blue_average (results.blue_average),
  .block_column (results.block_column),
  .block_row    (results.block_row),
  .frame_end    (results.frame_end)
);
